FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the box blur line block.
// No dependencies; compiled out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: hw/rtl/agbb_pkg.sv
// Package for the alpha gated box blur line block: widths, constants, types.
// No dependencies.
package agbb_pkg;

    localparam int unsigned PIX_W      = 32;
    localparam int unsigned CH_W       = 8;
    localparam int unsigned SUM_W      = 15;
    localparam int unsigned SEEN_W     = 7;
    localparam logic [6:0]  SEEN_MAX   = 7'd127;
    localparam int unsigned RADIUS_W   = 6;
    localparam int unsigned RADIUS_RST = 5;
    localparam int unsigned DIV_SHIFT  = 22;
    localparam int unsigned RECIP_W    = 21;

    typedef struct packed {
        logic             sel;
        logic [PIX_W-1:0] pix;
    } entry_t;

    typedef struct packed {
        logic [SUM_W-1:0] a;
        logic [SUM_W-1:0] r;
        logic [SUM_W-1:0] g;
        logic [SUM_W-1:0] b;
    } sums_t;

endpackage

FILE: hw/rtl/alpha_gated_box_blur_line_top.sv
// A result is registered in s1 (window sums), then in s2 (quotients), and leaves from s2.
// Throughput: 1 pixel per cycle unless out_ready stalls; a line_end pixel adds r flush steps
// (in_ready low), one shift of the cell chain per cycle unless stalled.
// Reset: control, running sums and line count clear, radius returns to 5; window cells are
// not reset, the first pixel of each line loads all of them.
module alpha_gated_box_blur_line_top #(
    parameter int MAX_RADIUS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [agbb_pkg::RADIUS_W-1:0]   cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [agbb_pkg::PIX_W-1:0]      in_pixel,
    input  logic                            in_selected,
    input  logic                            line_end,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [agbb_pkg::PIX_W-1:0]      out_pixel,
    output logic                            write_enable,
    output logic                            line_last
);

    `include "assert_macros.svh"

    localparam int RW    = $clog2(MAX_RADIUS + 1);
    localparam int IW    = RW + 1;
    localparam int DEPTH = 2 * MAX_RADIUS + 1;
    localparam int unsigned R_RST_I = (agbb_pkg::RADIUS_RST > MAX_RADIUS) ?
                                      MAX_RADIUS : agbb_pkg::RADIUS_RST;
    localparam int unsigned RST_D   = 2 * R_RST_I + 1;
    localparam int unsigned RECIP_RST_I = ((1 << agbb_pkg::DIV_SHIFT) + RST_D - 1) / RST_D;

    localparam int SW = agbb_pkg::SUM_W;
    localparam int CW = agbb_pkg::CH_W;

    // reciprocal table, ceil(2^K / (2r+1))
    logic [agbb_pkg::RECIP_W-1:0] recip_tab [MAX_RADIUS+1];

    for (genvar g = 0; g <= MAX_RADIUS; g++)
    begin : g_recip
        localparam int unsigned D = 2 * g + 1;
        localparam int unsigned M = ((1 << agbb_pkg::DIV_SHIFT) + D - 1) / D;
        assign recip_tab[g] = agbb_pkg::RECIP_W'(M);
    end

    logic [RW-1:0]                   r_reg;
    logic [agbb_pkg::RECIP_W-1:0]    recip_reg;
    logic [agbb_pkg::SEEN_W-1:0]     seen_reg;
    logic [agbb_pkg::SEEN_W-1:0]     seen_next;
    logic [RW-1:0]                   fl_cnt_reg;
    logic [RW-1:0]                   fl_cnt_next;
    agbb_pkg::sums_t                 sum_reg;
    agbb_pkg::sums_t                 sum_next;

    logic                            v1_reg;
    agbb_pkg::sums_t                 s1_sum_reg;
    logic                            s1_sel_reg;
    logic                            s1_last_reg;
    logic                            v2_reg;
    logic                            s2_sel_reg;
    logic                            s2_last_reg;

    logic                            s1_ready;
    logic                            s2_ready;
    logic                            in_acc;
    logic                            flush_active;
    logic                            flush_step;
    logic                            step_en;
    logic                            fill;
    logic                            emit;
    logic                            last_step;
    logic [RW-1:0]                   r_clamp;
    logic [IW-1:0]                   two_r;
    logic [IW-1:0]                   r_m1;
    logic [SW-1:0]                   win_len;

    agbb_pkg::entry_t                step_entry;
    agbb_pkg::entry_t                centre_next;
    agbb_pkg::entry_t                tail;
    agbb_pkg::entry_t                cell_q [DEPTH];
    agbb_pkg::sums_t                 add_c;
    agbb_pkg::sums_t                 sub_c;

    // cell chain, newest entry in cell 0
    for (genvar k = 0; k < DEPTH; k++)
    begin : g_cell
        agbb_cell u_cell (
            .clk        (clk),
            .en         (step_en),
            .load       (fill),
            .load_data  (step_entry),
            .shift_data ((k == 0) ? step_entry : cell_q[(k == 0) ? 0 : k - 1]),
            .q          (cell_q[k])
        );
    end

    assign s2_ready     = !v2_reg || out_ready;
    assign s1_ready     = !v1_reg || s2_ready;
    assign flush_active = (fl_cnt_reg != '0);
    assign in_ready     = s1_ready && !flush_active;
    assign in_acc       = in_valid && in_ready;
    assign flush_step   = flush_active && s1_ready;
    assign step_en      = in_acc || flush_step;
    assign fill         = in_acc && (seen_reg == '0);
    assign emit         = (seen_reg >= agbb_pkg::SEEN_W'(r_reg));
    assign last_step    = flush_step && (fl_cnt_reg == RW'(1));

    assign two_r   = {r_reg, 1'b0};
    assign r_m1    = {1'b0, r_reg} - IW'(1);
    assign win_len = SW'({r_reg, 1'b1});

    assign step_entry  = flush_active ? cell_q[0] : {in_selected, in_pixel};
    assign tail        = cell_q[two_r];
    assign centre_next = fill ? step_entry : cell_q[r_m1];

    always_comb
    begin
        r_clamp = RW'(cfg_data);
        if (cfg_data == '0)
        begin
            r_clamp = RW'(1);
        end
        else if (cfg_data > agbb_pkg::RADIUS_W'(MAX_RADIUS))
        begin
            r_clamp = RW'(MAX_RADIUS);
        end
    end

    // color channels count only where alpha is nonzero
    always_comb
    begin
        add_c.a = SW'(step_entry.pix[31:24]);
        add_c.r = (step_entry.pix[31:24] != '0) ? SW'(step_entry.pix[23:16]) : '0;
        add_c.g = (step_entry.pix[31:24] != '0) ? SW'(step_entry.pix[15:8]) : '0;
        add_c.b = (step_entry.pix[31:24] != '0) ? SW'(step_entry.pix[7:0]) : '0;
        sub_c.a = SW'(tail.pix[31:24]);
        sub_c.r = (tail.pix[31:24] != '0) ? SW'(tail.pix[23:16]) : '0;
        sub_c.g = (tail.pix[31:24] != '0) ? SW'(tail.pix[15:8]) : '0;
        sub_c.b = (tail.pix[31:24] != '0) ? SW'(tail.pix[7:0]) : '0;
        if (fill)
        begin
            sum_next.a = win_len * add_c.a;
            sum_next.r = win_len * add_c.r;
            sum_next.g = win_len * add_c.g;
            sum_next.b = win_len * add_c.b;
        end
        else
        begin
            sum_next.a = sum_reg.a + add_c.a - sub_c.a;
            sum_next.r = sum_reg.r + add_c.r - sub_c.r;
            sum_next.g = sum_reg.g + add_c.g - sub_c.g;
            sum_next.b = sum_reg.b + add_c.b - sub_c.b;
        end
    end

    always_comb
    begin
        seen_next   = seen_reg;
        fl_cnt_next = fl_cnt_reg;
        if (cfg_we)
        begin
            seen_next = '0;
        end
        else if (step_en)
        begin
            if (last_step)
            begin
                seen_next = '0;
            end
            else if (seen_reg < agbb_pkg::SEEN_MAX)
            begin
                seen_next = seen_reg + agbb_pkg::SEEN_W'(1);
            end
        end
        if (in_acc && line_end)
        begin
            fl_cnt_next = r_reg;
        end
        else if (flush_step)
        begin
            fl_cnt_next = fl_cnt_reg - RW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_reg      <= RW'(R_RST_I);
            recip_reg  <= agbb_pkg::RECIP_W'(RECIP_RST_I);
            seen_reg   <= '0;
            fl_cnt_reg <= '0;
            sum_reg    <= '0;
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                r_reg     <= r_clamp;
                recip_reg <= recip_tab[r_clamp];
            end
            seen_reg   <= seen_next;
            fl_cnt_reg <= fl_cnt_next;
            if (step_en)
            begin
                sum_reg <= sum_next;
            end
            if (s1_ready)
            begin
                v1_reg <= step_en && emit;
            end
            if (s2_ready)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            s1_sum_reg  <= sum_next;
            s1_sel_reg  <= centre_next.sel;
            s1_last_reg <= last_step;
        end
        if (s2_ready)
        begin
            s2_sel_reg  <= s1_sel_reg;
            s2_last_reg <= s1_last_reg;
        end
    end

    agbb_div u_div_b (
        .clk   (clk),
        .en    (s2_ready),
        .sum   (s1_sum_reg.b),
        .recip (recip_reg),
        .quot  (out_pixel[CW-1:0])
    );

    agbb_div u_div_g (
        .clk   (clk),
        .en    (s2_ready),
        .sum   (s1_sum_reg.g),
        .recip (recip_reg),
        .quot  (out_pixel[2*CW-1:CW])
    );

    agbb_div u_div_r (
        .clk   (clk),
        .en    (s2_ready),
        .sum   (s1_sum_reg.r),
        .recip (recip_reg),
        .quot  (out_pixel[3*CW-1:2*CW])
    );

    agbb_div u_div_a (
        .clk   (clk),
        .en    (s2_ready),
        .sum   (s1_sum_reg.a),
        .recip (recip_reg),
        .quot  (out_pixel[4*CW-1:3*CW])
    );

    assign out_valid    = v2_reg;
    assign write_enable = s2_sel_reg;
    assign line_last    = s2_last_reg;

    `ASSERT_NEXT(a_end_starts_flush, clk, rst_n, in_acc && line_end, flush_active)
    `ASSERT_NEXT(a_flush_closes_line, clk, rst_n, last_step && !cfg_we, seen_reg == '0)
    `ASSERT_NEXT(a_s1_holds_on_stall, clk, rst_n, v1_reg && !s2_ready, v1_reg && $stable(s1_sum_reg))
    `ASSERT_IMPL(a_radius_in_range, clk, rst_n, 1'b1, (r_reg != '0) && (r_reg <= RW'(MAX_RADIUS)))

endmodule

FILE: hw/rtl/agbb_cell.sv
// One window cell: holds a pixel entry, loads the line's first pixel or
// takes its neighbor's entry on each step. Depends on agbb_pkg.
module agbb_cell (
    input  logic              clk,
    input  logic              en,
    input  logic              load,
    input  agbb_pkg::entry_t  load_data,
    input  agbb_pkg::entry_t  shift_data,
    output agbb_pkg::entry_t  q
);

    agbb_pkg::entry_t q_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= load ? load_data : shift_data;
        end
    end

    assign q = q_reg;

endmodule

FILE: hw/rtl/agbb_div.sv
// Exact floor division of one channel sum by 2r+1 via a reciprocal multiply.
// Registered quotient byte. Depends on agbb_pkg.
module agbb_div (
    input  logic                              clk,
    input  logic                              en,
    input  logic [agbb_pkg::SUM_W-1:0]        sum,
    input  logic [agbb_pkg::RECIP_W-1:0]      recip,
    output logic [agbb_pkg::CH_W-1:0]         quot
);

    localparam int unsigned PROD_W = agbb_pkg::SUM_W + agbb_pkg::RECIP_W;

    logic [PROD_W-1:0]          prod;
    logic [agbb_pkg::CH_W-1:0]  quot_reg;

    assign prod = PROD_W'(sum) * PROD_W'(recip);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quot_reg <= prod[agbb_pkg::DIV_SHIFT + agbb_pkg::CH_W - 1:agbb_pkg::DIV_SHIFT];
        end
    end

    assign quot = quot_reg;

endmodule
